// ===== hdl/heun_pkg.sv =====
// ----------------------------------------------------------------------------
// Heun solver package
// Shared types, constants and saturating arithmetic helpers for the
// second-order Heun solver.
// ----------------------------------------------------------------------------
package heun_pkg;

   localparam int DATA_W        = 32;
   localparam int PROD_W        = 64;
   localparam int CSR_INDEX_W   = 3;
   localparam int MAX_STEPS_DEF = 4096;
   localparam int FRAC_BITS_DEF = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_X     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_VALUE = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_SLOPE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SIZE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_X      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_SLOPE  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_VALUE  = 3'd6;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_K0,
      OP_K1,
      OP_K2,
      OP_YP,
      OP_SP,
      OP_KP0,
      OP_KP1,
      OP_KP2,
      OP_Y,
      OP_S
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_K0,
      ST_K1,
      ST_K2,
      ST_YP,
      ST_SP,
      ST_KP0,
      ST_KP1,
      ST_KP2,
      ST_Y,
      ST_GAP,
      ST_S,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic   load_target;
      logic   init;
      op_type op;
      logic   calc_xh;
      logic   calc_u;
      logic   calc_v;
      logic   advance_x;
      logic   load_rsp;
   } cmd_type;

   typedef struct packed {
      logic x_at_target;
   } status_type;

   function automatic logic signed [DATA_W-1:0] sat_wide(
      input logic signed [PROD_W-1:0] v
   );
      logic signed [DATA_W-1:0] r;
      if (v[PROD_W-1:DATA_W-1] != {(PROD_W-DATA_W+1){v[PROD_W-1]}}) begin
         r = v[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_add(
      input logic signed [DATA_W-1:0] a,
      input logic signed [DATA_W-1:0] b
   );
      logic signed [DATA_W:0]   s;
      logic signed [DATA_W-1:0] r;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      if (s[DATA_W] != s[DATA_W-1]) begin
         r = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         r = s[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/heun_ctrl.sv =====
// ----------------------------------------------------------------------------
// Heun solver controller
// Sequences the datapath through the operations of each Heun step, counts
// steps, and runs the request and response handshakes.
// ----------------------------------------------------------------------------
module heun_ctrl #(
   parameter int MAX_STEPS = heun_pkg::MAX_STEPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  heun_pkg::status_type status,
   output heun_pkg::cmd_type    cmd
);

   localparam int STEP_W = $clog2(MAX_STEPS + 1);

   heun_pkg::state_type state_ff, state_in;
   logic [STEP_W-1:0]   steps_ff, steps_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                run_done;
   logic                rsp_free;

   assign run_done  = status.x_at_target || (steps_ff == STEP_W'(MAX_STEPS));
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != heun_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         heun_pkg::ST_IDLE:   if (req_valid) state_in = heun_pkg::ST_INIT;
         heun_pkg::ST_INIT:   state_in = heun_pkg::ST_K0;
         heun_pkg::ST_K0:     state_in = run_done ? heun_pkg::ST_FINISH : heun_pkg::ST_K1;
         heun_pkg::ST_K1:     state_in = heun_pkg::ST_K2;
         heun_pkg::ST_K2:     state_in = heun_pkg::ST_YP;
         heun_pkg::ST_YP:     state_in = heun_pkg::ST_SP;
         heun_pkg::ST_SP:     state_in = heun_pkg::ST_KP0;
         heun_pkg::ST_KP0:    state_in = heun_pkg::ST_KP1;
         heun_pkg::ST_KP1:    state_in = heun_pkg::ST_KP2;
         heun_pkg::ST_KP2:    state_in = heun_pkg::ST_Y;
         heun_pkg::ST_Y:      state_in = heun_pkg::ST_GAP;
         heun_pkg::ST_GAP:    state_in = heun_pkg::ST_S;
         heun_pkg::ST_S:      state_in = heun_pkg::ST_K0;
         heun_pkg::ST_FINISH: if (rsp_free) state_in = heun_pkg::ST_IDLE;
         default:             state_in = heun_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.op = heun_pkg::OP_NONE;
      case (state_ff)
         heun_pkg::ST_IDLE: begin
            cmd.load_target = req_valid;
         end
         heun_pkg::ST_INIT: begin
            cmd.init = 1'b1;
         end
         heun_pkg::ST_K0: begin
            if (!run_done) begin
               cmd.op      = heun_pkg::OP_K0;
               cmd.calc_xh = 1'b1;
            end
         end
         heun_pkg::ST_K1:  cmd.op = heun_pkg::OP_K1;
         heun_pkg::ST_K2:  cmd.op = heun_pkg::OP_K2;
         heun_pkg::ST_YP:  cmd.op = heun_pkg::OP_YP;
         heun_pkg::ST_SP:  cmd.op = heun_pkg::OP_SP;
         heun_pkg::ST_KP0: cmd.op = heun_pkg::OP_KP0;
         heun_pkg::ST_KP1: begin
            cmd.op     = heun_pkg::OP_KP1;
            cmd.calc_u = 1'b1;
         end
         heun_pkg::ST_KP2: cmd.op = heun_pkg::OP_KP2;
         heun_pkg::ST_Y:   cmd.op = heun_pkg::OP_Y;
         heun_pkg::ST_GAP: begin
            cmd.calc_v = 1'b1;
         end
         heun_pkg::ST_S: begin
            cmd.op        = heun_pkg::OP_S;
            cmd.advance_x = 1'b1;
         end
         heun_pkg::ST_FINISH: begin
            cmd.load_rsp = rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      steps_in = steps_ff;
      if (state_ff == heun_pkg::ST_INIT) begin
         steps_in = '0;
      end else if (state_ff == heun_pkg::ST_S) begin
         steps_in = steps_ff + STEP_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == heun_pkg::ST_FINISH && rsp_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= heun_pkg::ST_IDLE;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/heun_dp.sv =====
// ----------------------------------------------------------------------------
// Heun solver datapath
// Configuration registers, solution state, one shared multiplier with a
// registered product, and the shift, saturate and accumulate stage behind it.
// ----------------------------------------------------------------------------
module heun_dp #(
   parameter int FRAC_BITS = heun_pkg::FRAC_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_we,
   input  logic [heun_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  logic [heun_pkg::DATA_W-1:0]               csr_wdata,
   input  logic signed [heun_pkg::DATA_W-1:0]        req_target_x,
   output logic signed [heun_pkg::DATA_W-1:0]        rsp_value_at_target,
   output logic                                      rsp_not_reached,
   input  heun_pkg::cmd_type                         cmd,
   output heun_pkg::status_type                      status
);

   localparam int W = heun_pkg::DATA_W;
   localparam int P = heun_pkg::PROD_W;

   localparam logic signed [P-1:0] STEP_RST =
      ((64'sd1 <<< FRAC_BITS) + 64'sd5) / 64'sd10;
   localparam logic signed [P-1:0] COEF_X_RST     = 64'sd8 <<< FRAC_BITS;
   localparam logic signed [P-1:0] COEF_SLOPE_RST = -(64'sd4 <<< FRAC_BITS);
   localparam logic signed [P-1:0] COEF_VALUE_RST = -(64'sd5 <<< FRAC_BITS);

   logic signed [W-1:0] start_x_ff, start_x_in;
   logic signed [W-1:0] start_value_ff, start_value_in;
   logic signed [W-1:0] start_slope_ff, start_slope_in;
   logic signed [W-1:0] step_ff, step_in;
   logic signed [W-1:0] coef_x_ff, coef_x_in;
   logic signed [W-1:0] coef_slope_ff, coef_slope_in;
   logic signed [W-1:0] coef_value_ff, coef_value_in;

   logic signed [W-1:0] target_ff, target_in;
   logic signed [W-1:0] x_ff, x_in;
   logic signed [W-1:0] y_ff, y_in;
   logic signed [W-1:0] s_ff, s_in;
   logic signed [W-1:0] xh_ff, xh_in;
   logic signed [W-1:0] t_ff, t_in;
   logic signed [W-1:0] k_ff, k_in;
   logic signed [W-1:0] yp_ff, yp_in;
   logic signed [W-1:0] sp_ff, sp_in;
   logic signed [W-1:0] kp_ff, kp_in;
   logic signed [W-1:0] u_ff, u_in;
   logic signed [W-1:0] v_ff, v_in;
   logic signed [P-1:0] prod_ff, prod_in;
   heun_pkg::op_type    op_ff, op_in;
   logic signed [W-1:0] rsp_value_ff, rsp_value_in;
   logic                rsp_flag_ff, rsp_flag_in;

   logic signed [W-1:0] mul_a;
   logic signed [W-1:0] mul_b;
   logic signed [W-1:0] q_full;
   logic signed [W-1:0] q_half;
   logic signed [W-1:0] q;

   always_comb begin
      start_x_in     = start_x_ff;
      start_value_in = start_value_ff;
      start_slope_in = start_slope_ff;
      step_in        = step_ff;
      coef_x_in      = coef_x_ff;
      coef_slope_in  = coef_slope_ff;
      coef_value_in  = coef_value_ff;
      if (csr_we) begin
         case (csr_index)
            heun_pkg::CSR_START_X:     start_x_in     = csr_wdata;
            heun_pkg::CSR_START_VALUE: start_value_in = csr_wdata;
            heun_pkg::CSR_START_SLOPE: start_slope_in = csr_wdata;
            heun_pkg::CSR_STEP_SIZE:   step_in        = csr_wdata;
            heun_pkg::CSR_COEF_X:      coef_x_in      = csr_wdata;
            heun_pkg::CSR_COEF_SLOPE:  coef_slope_in  = csr_wdata;
            heun_pkg::CSR_COEF_VALUE:  coef_value_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         heun_pkg::OP_K0:  begin mul_a = coef_x_ff;     mul_b = x_ff;  end
         heun_pkg::OP_K1:  begin mul_a = coef_slope_ff; mul_b = s_ff;  end
         heun_pkg::OP_K2:  begin mul_a = coef_value_ff; mul_b = y_ff;  end
         heun_pkg::OP_YP:  begin mul_a = step_ff;       mul_b = s_ff;  end
         heun_pkg::OP_SP:  begin mul_a = step_ff;       mul_b = k_ff;  end
         heun_pkg::OP_KP0: begin mul_a = coef_x_ff;     mul_b = xh_ff; end
         heun_pkg::OP_KP1: begin mul_a = coef_slope_ff; mul_b = sp_ff; end
         heun_pkg::OP_KP2: begin mul_a = coef_value_ff; mul_b = yp_ff; end
         heun_pkg::OP_Y:   begin mul_a = step_ff;       mul_b = u_ff;  end
         heun_pkg::OP_S:   begin mul_a = step_ff;       mul_b = v_ff;  end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = P'(mul_a) * P'(mul_b);
      op_in   = cmd.op;
   end

   assign q_full = heun_pkg::sat_wide(prod_ff >>> FRAC_BITS);
   assign q_half = heun_pkg::sat_wide(prod_ff >>> (FRAC_BITS + 1));
   assign q      = (op_ff == heun_pkg::OP_Y || op_ff == heun_pkg::OP_S) ? q_half : q_full;

   always_comb begin
      target_in    = target_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      s_in         = s_ff;
      xh_in        = xh_ff;
      t_in         = t_ff;
      k_in         = k_ff;
      yp_in        = yp_ff;
      sp_in        = sp_ff;
      kp_in        = kp_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      rsp_value_in = rsp_value_ff;
      rsp_flag_in  = rsp_flag_ff;

      case (op_ff)
         heun_pkg::OP_K0:  t_in  = q;
         heun_pkg::OP_K1:  t_in  = heun_pkg::sat_add(t_ff, q);
         heun_pkg::OP_K2:  k_in  = heun_pkg::sat_add(t_ff, q);
         heun_pkg::OP_YP:  yp_in = heun_pkg::sat_add(y_ff, q);
         heun_pkg::OP_SP:  sp_in = heun_pkg::sat_add(s_ff, q);
         heun_pkg::OP_KP0: t_in  = q;
         heun_pkg::OP_KP1: t_in  = heun_pkg::sat_add(t_ff, q);
         heun_pkg::OP_KP2: kp_in = heun_pkg::sat_add(t_ff, q);
         heun_pkg::OP_Y:   y_in  = heun_pkg::sat_add(y_ff, q);
         heun_pkg::OP_S:   s_in  = heun_pkg::sat_add(s_ff, q);
         default: begin
         end
      endcase

      if (cmd.calc_xh)   xh_in = heun_pkg::sat_add(x_ff, step_ff);
      if (cmd.calc_u)    u_in  = heun_pkg::sat_add(s_ff, sp_ff);
      if (cmd.calc_v)    v_in  = heun_pkg::sat_add(k_ff, kp_ff);
      if (cmd.advance_x) x_in  = xh_ff;
      if (cmd.load_target) target_in = req_target_x;
      if (cmd.init) begin
         x_in = start_x_ff;
         y_in = start_value_ff;
         s_in = start_slope_ff;
      end
      if (cmd.load_rsp) begin
         rsp_value_in = y_ff;
         rsp_flag_in  = (x_ff != target_ff);
      end
   end

   assign status.x_at_target = (x_ff == target_ff);
   assign rsp_value_at_target = rsp_value_ff;
   assign rsp_not_reached     = rsp_flag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff     <= '0;
         start_value_ff <= '0;
         start_slope_ff <= '0;
         step_ff        <= STEP_RST[W-1:0];
         coef_x_ff      <= COEF_X_RST[W-1:0];
         coef_slope_ff  <= COEF_SLOPE_RST[W-1:0];
         coef_value_ff  <= COEF_VALUE_RST[W-1:0];
         op_ff          <= heun_pkg::OP_NONE;
      end else begin
         start_x_ff     <= start_x_in;
         start_value_ff <= start_value_in;
         start_slope_ff <= start_slope_in;
         step_ff        <= step_in;
         coef_x_ff      <= coef_x_in;
         coef_slope_ff  <= coef_slope_in;
         coef_value_ff  <= coef_value_in;
         op_ff          <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff    <= target_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      s_ff         <= s_in;
      xh_ff        <= xh_in;
      t_ff         <= t_in;
      k_ff         <= k_in;
      yp_ff        <= yp_in;
      sp_ff        <= sp_in;
      kp_ff        <= kp_in;
      u_ff         <= u_in;
      v_ff         <= v_in;
      prod_ff      <= prod_in;
      rsp_value_ff <= rsp_value_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

endmodule

// ===== hdl/heun_second_order_ode_solver.sv =====
// ----------------------------------------------------------------------------
// Heun second-order ODE solver
// Solves y'' = a*x + b*y' + c*y from a configured initial point by Heun
// steps in signed fixed point, returning y where x reaches the requested
// target.
//
//   Channel   Direction  Handshake             Payload
//   req       in         req_valid/req_stall   req_target_x
//   rsp       out        rsp_valid/rsp_stall   rsp_value_at_target, rsp_not_reached
//   csr       in         csr_we                csr_index, csr_wdata
//
// A transaction runs up to MAX_STEPS Heun steps; each step is ten products
// through the single shared multiplier plus a wait state (ST_GAP) for the
// second slope sum.
// One transaction is solved at a time; a new request is taken while the
// previous response still waits in the output register.
// Reset is synchronous and loads the default coefficients and step size.
// A stalled response holds the solver in its final state until taken.
// ----------------------------------------------------------------------------
module heun_second_order_ode_solver #(
   parameter int MAX_STEPS = heun_pkg::MAX_STEPS_DEF,
   parameter int FRAC_BITS = heun_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [heun_pkg::DATA_W-1:0]   req_target_x,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [heun_pkg::DATA_W-1:0]   rsp_value_at_target,
   output logic                                 rsp_not_reached,
   input  logic                                 csr_we,
   input  logic [heun_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [heun_pkg::DATA_W-1:0]          csr_wdata
);

   heun_pkg::cmd_type    cmd;
   heun_pkg::status_type status;

   heun_ctrl #(
      .MAX_STEPS (MAX_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   heun_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_target_x        (req_target_x),
      .rsp_value_at_target (rsp_value_at_target),
      .rsp_not_reached     (rsp_not_reached),
      .cmd                 (cmd),
      .status              (status)
   );

endmodule

// ===== tb/heun_second_order_ode_solver_test.sv =====
// ----------------------------------------------------------------------------
// Heun second-order ODE solver testbench
// Drives target points into the solver under a series of register settings.
// The settings include the reset defaults, saturating extremes, zero and
// wrong-sign step lengths, and random settings. A scoreboard runs the same
// fixed-point Heun iteration for every accepted request. It checks each
// response, in order, against its own solution. Both channels idle and stall
// at random. The receiver also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module heun_second_order_ode_solver_test;

   typedef logic signed [heun_pkg::DATA_W-1:0] fixed_type;

   typedef struct {
      fixed_type value;
      logic      not_reached;
   } solution_type;

   localparam int CLOCK_PERIOD     = 4;
   localparam int RESET_CYCLES     = 9;
   localparam int TIMEOUT_CYCLES   = 20_000_000;
   localparam int SETTLE_CYCLES    = 16;
   localparam int LONG_HOLD_AFTER  = 40;
   localparam int LONG_HOLD_CYCLES = 2000;
   localparam int RANDOM_PHASES    = 5;
   localparam int ITEMS_PER_PHASE  = 18;
   localparam int MAX_LANDING      = 40;
   localparam int STEP_LIMIT       = heun_pkg::MAX_STEPS_DEF;
   localparam int FRAC_ONE         = 1 << heun_pkg::FRAC_BITS_DEF;
   localparam int DEFAULT_STEP     = (FRAC_ONE + 5) / 10;

   localparam fixed_type WORD_MAX = 32'sh7FFF_FFFF;
   localparam fixed_type WORD_MIN = 32'sh8000_0000;
   localparam logic [heun_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;

   class heun_scoreboard;
      fixed_type    origin_x;
      fixed_type    origin_value;
      fixed_type    origin_slope;
      fixed_type    step_len;
      fixed_type    gain_x;
      fixed_type    gain_slope;
      fixed_type    gain_value;
      solution_type pending[$];
      int           failures;
      int           solved;

      function new();
         origin_x     = 0;
         origin_value = 0;
         origin_slope = 0;
         step_len     = DEFAULT_STEP;
         gain_x       = 8 * FRAC_ONE;
         gain_slope   = -4 * FRAC_ONE;
         gain_value   = -5 * FRAC_ONE;
         failures     = 0;
         solved       = 0;
      endfunction

      function void set_register(logic [heun_pkg::CSR_INDEX_W-1:0] index,
                                 fixed_type value);
         case (index)
            heun_pkg::CSR_START_X:     origin_x = value;
            heun_pkg::CSR_START_VALUE: origin_value = value;
            heun_pkg::CSR_START_SLOPE: origin_slope = value;
            heun_pkg::CSR_STEP_SIZE:   step_len = value;
            heun_pkg::CSR_COEF_X:      gain_x = value;
            heun_pkg::CSR_COEF_SLOPE:  gain_slope = value;
            heun_pkg::CSR_COEF_VALUE:  gain_value = value;
            default: ;
         endcase
      endfunction

      function fixed_type clamp_word(longint v);
         if (v > longint'(WORD_MAX)) return WORD_MAX;
         else if (v < longint'(WORD_MIN)) return WORD_MIN;
         else return fixed_type'(v);
      endfunction

      function fixed_type add_sat(fixed_type a, fixed_type b);
         return clamp_word(longint'(a) + longint'(b));
      endfunction

      function fixed_type mul_shift(fixed_type a, fixed_type b, int sh);
         longint p;
         p = longint'(a) * longint'(b);
         return clamp_word(p >>> sh);
      endfunction

      function fixed_type accel(fixed_type x, fixed_type y, fixed_type s);
         fixed_type t;
         t = mul_shift(gain_x, x, heun_pkg::FRAC_BITS_DEF);
         t = add_sat(t, mul_shift(gain_slope, s, heun_pkg::FRAC_BITS_DEF));
         return add_sat(t, mul_shift(gain_value, y, heun_pkg::FRAC_BITS_DEF));
      endfunction

      function fixed_type landing_point(int unsigned steps);
         fixed_type x;
         x = origin_x;
         repeat (steps) x = add_sat(x, step_len);
         return x;
      endfunction

      function int outstanding();
         return pending.size();
      endfunction

      function void record_target(fixed_type target);
         fixed_type    x, y, s, k, kp, xh, yp, sp, ny, ns;
         int unsigned  n;
         solution_type sol;
         x = origin_x;
         y = origin_value;
         s = origin_slope;
         n = 0;
         while (x != target && n < STEP_LIMIT) begin
            k  = accel(x, y, s);
            xh = add_sat(x, step_len);
            yp = add_sat(y, mul_shift(step_len, s, heun_pkg::FRAC_BITS_DEF));
            sp = add_sat(s, mul_shift(step_len, k, heun_pkg::FRAC_BITS_DEF));
            kp = accel(xh, yp, sp);
            ny = add_sat(y, mul_shift(step_len, add_sat(s, sp), heun_pkg::FRAC_BITS_DEF + 1));
            ns = add_sat(s, mul_shift(step_len, add_sat(k, kp), heun_pkg::FRAC_BITS_DEF + 1));
            y  = ny;
            s  = ns;
            x  = xh;
            n++;
         end
         sol.value       = y;
         sol.not_reached = (x != target);
         pending.push_back(sol);
      endfunction

      function void compare_solution(fixed_type value, logic not_reached);
         solution_type sol;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response: value_at_target %0d, not_reached %b",
                     $time, value, not_reached);
            failures++;
         end else begin
            sol = pending.pop_front();
            solved++;
            if (value !== sol.value) begin
               $display("%0t: value_at_target mismatch: expected %0d, actual %0d",
                        $time, sol.value, value);
               failures++;
            end
            if (not_reached !== sol.not_reached) begin
               $display("%0t: not_reached mismatch: expected %b, actual %b",
                        $time, sol.not_reached, not_reached);
               failures++;
            end
         end
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   fixed_type                        req_target_x;
   logic                             rsp_valid;
   logic                             rsp_stall;
   fixed_type                        rsp_value_at_target;
   logic                             rsp_not_reached;
   logic                             csr_we;
   logic [heun_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [heun_pkg::DATA_W-1:0]      csr_wdata;

   heun_scoreboard solver_model = new();

   heun_second_order_ode_solver uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_target_x        (req_target_x),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_value_at_target (rsp_value_at_target),
      .rsp_not_reached     (rsp_not_reached),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("end of test: mismatches");
      $finish;
   end

   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 85) return $urandom_range(1, 3);
      else if (r < 96) return $urandom_range(4, 20);
      else return $urandom_range(40, 150);
   endfunction

   function automatic fixed_type random_fixed();
      fixed_type v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            v = fixed_type'($urandom_range(0, 10 * FRAC_ONE));
            if ($urandom_range(0, 1) == 1) v = -v;
         end
         5, 6, 7: v = fixed_type'($urandom());
         8: v = WORD_MAX;
         default: v = ($urandom_range(0, 1) == 1) ? WORD_MIN : fixed_type'(0);
      endcase
      return v;
   endfunction

   function automatic fixed_type random_step();
      fixed_type v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5, 6: begin
            v = fixed_type'($urandom_range(1, 3 * FRAC_ONE));
            if ($urandom_range(0, 1) == 1) v = -v;
         end
         7, 8: begin
            v = fixed_type'($urandom());
            if (v == 0) v = 1;
         end
         default: v = ($urandom_range(0, 1) == 1) ? WORD_MIN : WORD_MAX;
      endcase
      return v;
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         solver_model.record_target(req_target_x);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         solver_model.compare_solution(rsp_value_at_target, rsp_not_reached);
      end
   end

   initial begin : response_side
      int unsigned hold;
      bit          long_hold_done;
      rsp_stall = 1'b0;
      long_hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (!long_hold_done && solver_model.solved >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if ((solver_model.solved / 16) % 3 == 1) begin
            rsp_stall <= 1'b0;
         end else begin
            hold = gap_length();
            if (hold > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(negedge clock);
            end
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic write_register(input logic [heun_pkg::CSR_INDEX_W-1:0] index,
                                 input fixed_type value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      solver_model.set_register(index, value);
      @(negedge clock);
   endtask

   task automatic configure(input fixed_type x0, input fixed_type y0, input fixed_type s0,
                            input fixed_type h, input fixed_type a, input fixed_type b,
                            input fixed_type c);
      write_register(CSR_UNUSED, fixed_type'($urandom()));
      write_register(heun_pkg::CSR_START_X, x0);
      write_register(heun_pkg::CSR_START_VALUE, y0);
      write_register(heun_pkg::CSR_START_SLOPE, s0);
      write_register(heun_pkg::CSR_STEP_SIZE, h);
      write_register(heun_pkg::CSR_COEF_X, a);
      write_register(heun_pkg::CSR_COEF_SLOPE, b);
      write_register(heun_pkg::CSR_COEF_VALUE, c);
      csr_we <= 1'b0;
   endtask

   task automatic offer_target(input fixed_type target, input bit steady);
      int unsigned gap;
      gap = steady ? 0 : gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_target_x <= target;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_for_solutions();
      req_valid <= 1'b0;
      while (solver_model.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : request_side
      fixed_type target;
      int        phase;
      int        item;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_target_x = '0;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The reset defaults are used first, without any register write.
      offer_target(0, 1'b0);
      offer_target(DEFAULT_STEP, 1'b0);
      offer_target(5 * DEFAULT_STEP, 1'b0);
      offer_target(MAX_LANDING * DEFAULT_STEP, 1'b0);
      offer_target(FRAC_ONE, 1'b0);
      wait_for_solutions();

      // The next settings saturate the arithmetic, and x lands on the top of its range.
      configure(WORD_MAX - 10, WORD_MAX, WORD_MIN, 4, WORD_MAX, WORD_MIN, WORD_MAX);
      offer_target(WORD_MAX - 10, 1'b0);
      offer_target(WORD_MAX - 6, 1'b0);
      offer_target(WORD_MAX, 1'b0);
      wait_for_solutions();

      configure(0, WORD_MIN, WORD_MAX, -FRAC_ONE, WORD_MIN, WORD_MAX, WORD_MIN);
      offer_target(-3 * FRAC_ONE, 1'b0);
      offer_target(FRAC_ONE, 1'b0);
      wait_for_solutions();

      configure(0, 32'sh0001_2345, -FRAC_ONE / 2, 0, 0, 0, 0);
      offer_target(0, 1'b0);
      offer_target(5, 1'b0);
      wait_for_solutions();

      configure(WORD_MAX, FRAC_ONE, -FRAC_ONE, WORD_MIN, 8 * FRAC_ONE, -4 * FRAC_ONE,
                -5 * FRAC_ONE);
      offer_target(-1, 1'b0);
      offer_target(WORD_MAX, 1'b0);
      wait_for_solutions();

      configure(WORD_MIN, -FRAC_ONE, FRAC_ONE, WORD_MAX, 8 * FRAC_ONE, -4 * FRAC_ONE,
                -5 * FRAC_ONE);
      offer_target(-1, 1'b0);
      wait_for_solutions();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         configure(random_fixed(), random_fixed(), random_fixed(), random_step(),
                   random_fixed(), random_fixed(), random_fixed());
         for (item = 0; item < ITEMS_PER_PHASE; item++) begin
            if ($urandom_range(0, 31) == 0) begin
               target = fixed_type'($urandom());
            end else begin
               target = solver_model.landing_point($urandom_range(0, MAX_LANDING));
            end
            offer_target(target, phase == 1);
         end
         wait_for_solutions();
      end

      if (solver_model.failures == 0 && solver_model.outstanding() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/heun_pkg.sv
hdl/heun_ctrl.sv
hdl/heun_dp.sv
hdl/heun_second_order_ode_solver.sv
tb/heun_second_order_ode_solver_test.sv
